// File: hw/rtl/mmu_pkg.sv
// ----------------------------------------------------------------------------
// mmu_pkg
// Shared constants and codes for the matrix multiply unit: dimension limit,
// command modes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package mmu_pkg;

  // Default largest matrix dimension held in the element stores
  localparam int MMU_MAX_DIM = 8;

  // Fixed field widths
  localparam int MMU_VAL_W = 16;  // signed Q8.8 element
  localparam int MMU_IDX_W = 3;   // row / column index ports
  localparam int MMU_DIM_W = 4;   // size registers
  localparam int MMU_PROD_W = 2 * MMU_VAL_W;
  localparam int MMU_FRAC_W = 8;

  // Command modes
  localparam logic [1:0] MODE_WR_A  = 2'd0;
  localparam logic [1:0] MODE_WR_B  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_A  = 2'd0;
  localparam logic [1:0] REG_INNER   = 2'd1;
  localparam logic [1:0] REG_COLS_B  = 2'd2;

endpackage

// File: hw/rtl/mmu_ram.sv
// ----------------------------------------------------------------------------
// mmu_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mmu_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_unit
// Operation: a start walks all rows*cols*inner products through the MAC; each
//   result passes the store read, multiply, accumulate and result registers.
// Throughput: one product per cycle through the single shared MAC; busy_o
//   stays high until the cycle after the last result strobe.
// Reset: async active-low; size registers reset to 1, stores are undefined.
// Results cannot be stalled: each is shown for one cycle with valid_o.
// ----------------------------------------------------------------------------
module matrix_multiply_unit
  import mmu_pkg::*;
#(
  parameter int MAX_DIM = MMU_MAX_DIM
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [MMU_DIM_W-1:0]        cfg_data_i,
  // command channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  mode_i,
  input  logic [MMU_IDX_W-1:0]        row_index_i,
  input  logic [MMU_IDX_W-1:0]        col_index_i,
  input  logic signed [MMU_VAL_W-1:0] element_value_i,
  // result channel
  output logic                        valid_o,
  output logic [MMU_IDX_W-1:0]        out_row_o,
  output logic [MMU_IDX_W-1:0]        out_col_o,
  output logic signed [MMU_VAL_W-1:0] out_value_o,
  output logic                        last_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ACCW  = MMU_PROD_W + $clog2(MAX_DIM) + 1;
  localparam int CMPW  = 6;

  localparam logic signed [ACCW-1:0] SAT_MAX = ACCW'(32767);
  localparam logic signed [ACCW-1:0] SAT_MIN = -(ACCW'(32768));

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Per-product tag travelling down the MAC pipeline
  typedef struct packed {
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic          first_k;
    logic          last_k;
    logic          last_all;
  } tag_t;

  // Effective last index of a size register (0 used as 1, clamp to MAX_DIM)
  function automatic logic [IW-1:0] dim_last(input logic [MMU_DIM_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (CMPW'(v) > CMPW'(MAX_DIM)) begin
      return IW'(MAX_DIM - 1);
    end else begin
      return IW'(v - MMU_DIM_W'(1));
    end
  endfunction

  logic [1:0]           state_q, state_d;
  logic [MMU_DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [IW-1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IW-1:0]        i_last, j_last, k_last;

  logic                 accept;
  logic                 in_range;
  logic                 we_a, we_b;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr_a, raddr_b;
  logic [MMU_VAL_W-1:0] rdata_a, rdata_b;

  tag_t                 tag_issue;
  logic                 issue;
  logic                 s1_vld_q, s2_vld_q, fin_vld_q;
  tag_t                 s1_tag_q, s2_tag_q, fin_tag_q;
  logic signed [MMU_PROD_W-1:0] prod_q;
  logic signed [ACCW-1:0]       acc_q, acc_d;
  logic signed [ACCW-1:0]       shr;
  logic signed [MMU_VAL_W-1:0]  sat;

  logic                        valid_q;
  logic                        last_q;
  logic [MMU_IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [MMU_VAL_W-1:0] out_value_q;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= MMU_DIM_W'(1);
      inner_q <= MMU_DIM_W'(1);
      cols_q  <= MMU_DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_A: rows_q  <= cfg_data_i;
        REG_INNER:  inner_q <= cfg_data_i;
        REG_COLS_B: cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign i_last = dim_last(rows_q);
  assign k_last = dim_last(inner_q);
  assign j_last = dim_last(cols_q);

  // Element writes: indexes outside the store are dropped
  assign in_range = (CMPW'(row_index_i) < CMPW'(MAX_DIM)) &&
                    (CMPW'(col_index_i) < CMPW'(MAX_DIM));
  assign we_a  = accept && (mode_i == MODE_WR_A) && in_range;
  assign we_b  = accept && (mode_i == MODE_WR_B) && in_range;
  assign waddr = AW'(IW'(row_index_i)) * AW'(MAX_DIM) + AW'(IW'(col_index_i));

  // Read addresses: A[i][k] and B[k][j]
  assign raddr_a = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
  assign raddr_b = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

  mmu_ram #(
    .Width (MMU_VAL_W),
    .Depth (Depth),
    .AddrW (AW)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mmu_ram #(
    .Width (MMU_VAL_W),
    .Depth (Depth),
    .AddrW (AW)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Issue tag for the product read this cycle
  assign issue              = (state_q == ST_ISSUE);
  assign tag_issue.row      = i_q;
  assign tag_issue.col      = j_q;
  assign tag_issue.first_k  = (k_q == '0);
  assign tag_issue.last_k   = (k_q == k_last);
  assign tag_issue.last_all = (k_q == k_last) && (j_q == j_last) && (i_q == i_last);

  // Sequencer: walks i, j, k in row-major order, k innermost
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == MODE_START)) begin
          state_d = ST_ISSUE;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (k_q != k_last) begin
          k_d = k_q + IW'(1);
        end else begin
          k_d = '0;
          if (j_q != j_last) begin
            j_d = j_q + IW'(1);
          end else begin
            j_d = '0;
            if (i_q != i_last) begin
              i_d = i_q + IW'(1);
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (valid_q && last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      fin_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      fin_vld_q <= s2_vld_q && s2_tag_q.last_k;
    end
  end

  // Shared MAC: multiply stage then accumulate stage
  assign acc_d = (s2_tag_q.first_k ? '0 : acc_q) + ACCW'(prod_q);

  always_ff @(posedge clk_i) begin
    s1_tag_q <= tag_issue;
    s2_tag_q <= s1_tag_q;
    prod_q   <= $signed(rdata_a) * $signed(rdata_b);
    if (s2_vld_q) begin
      acc_q     <= acc_d;
      fin_tag_q <= s2_tag_q;
    end
  end

  // Drop eight fraction bits (floor) and saturate to 16 bits
  assign shr = acc_q >>> MMU_FRAC_W;
  always_comb begin
    if (shr > SAT_MAX) begin
      sat = MMU_VAL_W'(SAT_MAX);
    end else if (shr < SAT_MIN) begin
      sat = MMU_VAL_W'(SAT_MIN);
    end else begin
      sat = MMU_VAL_W'(shr);
    end
  end

  // Result register: one-cycle strobe per element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= fin_vld_q;
      last_q  <= fin_vld_q && fin_tag_q.last_all;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_vld_q) begin
      out_row_q   <= MMU_IDX_W'(fin_tag_q.row);
      out_col_q   <= MMU_IDX_W'(fin_tag_q.col);
      out_value_q <= sat;
    end
  end

  assign valid_o     = valid_q;
  assign last_o      = last_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;

endmodule

// File: hw/rtl/mmu_checker.sv
// ----------------------------------------------------------------------------
// mmu_checker
// Port-level checks on the matrix multiply unit: results appear only during
// a run, a run starts and ends cleanly.
// ----------------------------------------------------------------------------
module mmu_checker
  import mmu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] mode_i,
  input logic       valid_o,
  input logic       last_o
);

  // Results only while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe outside a run");

  // A start transfer opens a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == MODE_START)) |=> busy_o)
    else $error("start did not raise busy");

  // The final result closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> (!busy_o && !valid_o))
    else $error("run did not end after last result");

  // A non-final result keeps the run open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> busy_o)
    else $error("run ended before last result");

  // No result appears out of an idle cycle without a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !(start_i && (mode_i == MODE_START))) |=> !valid_o)
    else $error("spurious result while idle");

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .mode_i  (mode_i),
  .valid_o (valid_o),
  .last_o  (last_o)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matrix_multiply_unit. Element loads and multiply
// starts go in over the start/busy command port. The bench keeps its own copy
// of both operand stores and of the size registers, and on every accepted
// start it queues the full product matrix in row-major order. Each result
// strobe is checked field by field against the head of that queue. Directed
// cases cover saturation, floor rounding, the unused mode, out-of-range and
// ignored size writes, and loads outside the active window. After those come
// random phases with random sizes and the largest sizes at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mmu_pkg::*;

  localparam int DIM = MMU_MAX_DIM;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int RANDOM_ITEMS  = 50;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;

  // One element of the product matrix as it leaves the block
  typedef struct {
    logic [MMU_IDX_W-1:0]        row;
    logic [MMU_IDX_W-1:0]        col;
    logic signed [MMU_VAL_W-1:0] value;
    logic                        last;
  } c_elem_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [1:0]                  cfg_idx_i = '0;
  logic [MMU_DIM_W-1:0]        cfg_data_i = '0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [1:0]                  mode_i = '0;
  logic [MMU_IDX_W-1:0]        row_index_i = '0;
  logic [MMU_IDX_W-1:0]        col_index_i = '0;
  logic signed [MMU_VAL_W-1:0] element_value_i = '0;
  logic                        valid_o;
  logic [MMU_IDX_W-1:0]        out_row_o;
  logic [MMU_IDX_W-1:0]        out_col_o;
  logic signed [MMU_VAL_W-1:0] out_value_o;
  logic                        last_o;

  // Bench copy of the operand stores and size registers
  logic signed [MMU_VAL_W-1:0] mat_a [DIM][DIM];
  logic signed [MMU_VAL_W-1:0] mat_b [DIM][DIM];
  bit                          a_written [DIM][DIM];
  bit                          b_written [DIM][DIM];
  logic [MMU_DIM_W-1:0]        rows_cfg  = 4'd1;
  logic [MMU_DIM_W-1:0]        inner_cfg = 4'd1;
  logic [MMU_DIM_W-1:0]        cols_cfg  = 4'd1;

  c_elem_t pending_c_q [$];
  c_elem_t head_elem;
  int      errors = 0;
  int      items_sent = 0;
  int      idle_pct = 35;
  int      quiet_cycles = 0;

  matrix_multiply_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .valid_o        (valid_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .out_value_o    (out_value_o),
    .last_o         (last_o)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Size as the block uses it: zero reads as one, above the store as the max
  function automatic int unsigned eff_dim(input logic [MMU_DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  // Full-precision dot products, floor shift by the fraction bits, saturate
  function automatic void predict_product();
    int unsigned nr, nk, nc;
    longint      acc;
    longint      scaled;
    c_elem_t     e;
    nr = eff_dim(rows_cfg);
    nk = eff_dim(inner_cfg);
    nc = eff_dim(cols_cfg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++)
          acc += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
        scaled = acc >>> MMU_FRAC_W;
        if (scaled > 32767)
          e.value = 16'sh7FFF;
        else if (scaled < -32768)
          e.value = 16'sh8000;
        else
          e.value = scaled[MMU_VAL_W-1:0];
        e.row  = 3'(i);
        e.col  = 3'(j);
        e.last = (i == nr - 1) && (j == nc - 1);
        pending_c_q = {pending_c_q, e};
      end
    end
  endfunction

  // Mostly small Q8.8 values so sums stay in range, some full-scale ones
  function automatic logic signed [MMU_VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  function automatic logic [MMU_DIM_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'($urandom_range(DIM + 1, 15));
      2: return 4'(DIM);
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // One command transfer; an optional idle burst goes ahead of it
  task automatic send_cmd(input logic [1:0] mode, input logic [2:0] row,
                          input logic [2:0] col, input logic signed [15:0] val);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    mode_i          <= mode;
    row_index_i     <= row;
    col_index_i     <= col;
    element_value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    case (mode)
      MODE_WR_A: begin
        mat_a[row][col]     = val;
        a_written[row][col] = 1'b1;
      end
      MODE_WR_B: begin
        mat_b[row][col]     = val;
        b_written[row][col] = 1'b1;
      end
      MODE_START: predict_product();
      default: ;
    endcase
  endtask

  // Let every queued result arrive, then let the block fall quiet
  task automatic drain_and_settle();
    start_i <= 1'b0;
    while (pending_c_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three size registers back to back, optionally the unused index
  task automatic set_sizes(input logic [3:0] rows, input logic [3:0] inner,
                           input logic [3:0] cols, input bit poke_unused);
    logic [1:0] idx [4];
    logic [3:0] dat [4];
    int         n;
    drain_and_settle();
    idx = '{REG_ROWS_A, REG_INNER, REG_COLS_B, REG_UNUSED};
    dat = '{rows, inner, cols, 4'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= dat[i];
      @(posedge clk_i);
      case (idx[i])
        REG_ROWS_A: rows_cfg  = dat[i];
        REG_INNER:  inner_cfg = dat[i];
        REG_COLS_B: cols_cfg  = dat[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // Load any operand entry the active window would read unwritten, then start
  task automatic start_multiply();
    int unsigned nr, nk, nc;
    nr = eff_dim(rows_cfg);
    nk = eff_dim(inner_cfg);
    nc = eff_dim(cols_cfg);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_written[i][k]) send_cmd(MODE_WR_A, 3'(i), 3'(k), rand_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_written[k][j]) send_cmd(MODE_WR_B, 3'(k), 3'(j), rand_value());
    send_cmd(MODE_START, 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  // Random load: mostly inside the active window, some anywhere, some unused
  task automatic random_load();
    int unsigned nr, nk, nc, pick;
    logic [1:0]  mode;
    logic [2:0]  row, col;
    nr   = eff_dim(rows_cfg);
    nk   = eff_dim(inner_cfg);
    nc   = eff_dim(cols_cfg);
    pick = $urandom_range(0, 9);
    mode = $urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A;
    row  = 3'($urandom);
    col  = 3'($urandom);
    if (pick == 0) begin
      mode = MODE_UNUSED;
    end else if (pick >= 2) begin
      if (mode == MODE_WR_A) begin
        row = 3'($urandom_range(0, nr - 1));
        col = 3'($urandom_range(0, nk - 1));
      end else begin
        row = 3'($urandom_range(0, nk - 1));
        col = 3'($urandom_range(0, nc - 1));
      end
    end
    send_cmd(mode, row, col, rand_value());
  endtask

  // Reset sizes are 1x1x1: saturation both ways, floor rounding, exact case
  task automatic test_saturation_and_rounding();
    send_cmd(MODE_WR_A, 3'd0, 3'd0, 16'sh7FFF);
    send_cmd(MODE_WR_B, 3'd0, 3'd0, 16'sh7FFF);
    send_cmd(MODE_START, 3'd7, 3'd7, 16'shFFFF);
    send_cmd(MODE_WR_A, 3'd0, 3'd0, 16'sh8000);
    send_cmd(MODE_START, 3'd0, 3'd0, 16'sh0000);
    send_cmd(MODE_WR_A, 3'd0, 3'd0, 16'sh0001);
    send_cmd(MODE_WR_B, 3'd0, 3'd0, 16'shFFFF);
    send_cmd(MODE_START, 3'd0, 3'd0, 16'sh0000);
    send_cmd(MODE_WR_A, 3'd0, 3'd0, 16'sh0100);
    send_cmd(MODE_WR_B, 3'd0, 3'd0, 16'sh0180);
    send_cmd(MODE_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  // Unused mode must not disturb anything; zero sizes act as one
  task automatic test_unused_mode_and_zero_sizes();
    send_cmd(MODE_UNUSED, 3'd7, 3'd7, 16'shFFFF);
    send_cmd(MODE_UNUSED, 3'd0, 3'd0, 16'sh0000);
    set_sizes(4'd0, 4'd0, 4'd0, 1'b1);
    send_cmd(MODE_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  // Loads outside the window are kept and used once the window grows
  task automatic test_write_beyond_sizes();
    set_sizes(4'd1, 4'd1, 4'd1, 1'b0);
    send_cmd(MODE_WR_A, 3'd0, 3'd1, 16'sh0200);
    send_cmd(MODE_WR_B, 3'd1, 3'd0, 16'shFD00);
    set_sizes(4'd1, 4'd2, 4'd1, 1'b0);
    send_cmd(MODE_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  // Random phases: new sizes, random loads, one or more multiplies each
  task automatic test_random_products();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      // short inner size keeps the operand loads per phase small
      set_sizes(pick_size(), 4'($urandom_range(0, 3)), pick_size(),
                $urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(1, 6)) random_load();
        start_multiply();
        // hold the sender until the whole product has come out
        if ($urandom_range(0, 3) == 0) drain_and_settle();
      end
    end
  endtask

  // Largest and clamped sizes on each axis, back to back with no idling
  task automatic test_largest_sizes();
    idle_pct = 0;
    set_sizes(4'd15, 4'd1, 4'd15, 1'b0);
    start_multiply();
    repeat (4) random_load();
    start_multiply();
    set_sizes(4'd1, 4'd15, 4'd1, 1'b0);
    start_multiply();
    set_sizes(4'(DIM), 4'd1, 4'(DIM), 1'b0);
    start_multiply();
  endtask

  task automatic check_field(input string name, input int expd, input int act);
    if (expd != act) begin
      $display("%0t ns: %s mismatch at (%0d,%0d): expected %0d, actual %0d",
               $time, name, head_elem.row, head_elem.col, expd, act);
      errors++;
    end
  endtask

  // Result checker: every strobe is one transfer, compared in order
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_c_q.size() == 0) begin
        $display("%0t ns: unexpected result: expected none, actual (%0d,%0d) %0d last %0b",
                 $time, out_row_o, out_col_o, out_value_o, last_o);
        errors++;
      end else begin
        head_elem = pending_c_q.pop_front();
        check_field("out_row", head_elem.row, out_row_o);
        check_field("out_col", head_elem.col, out_col_o);
        check_field("out_value", head_elem.value, out_value_o);
        check_field("last", head_elem.last, last_o);
      end
    end
  end

  // Count cycles without any transfer on either side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start_i && !busy_o) || valid_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_saturation_and_rounding();
    test_unused_mode_and_zero_sizes();
    test_write_beyond_sizes();
    test_random_products();
    test_largest_sizes();
    drain_and_settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
